>>> rtl/ecra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecra_pkg: shared types and constants
// Widths, arithmetic constants, register indexes and handshake structs for the
// encoder count to revolution and angle converter.
// ----------------------------------------------------------------------------
package ecra_pkg;

  // field widths
  localparam int RAW_W   = 16;
  localparam int POS_W   = 32;
  localparam int CPR_W   = 16;
  localparam int GEAR_W  = 10;
  localparam int THOU_W  = 10;
  localparam int DEG_W   = 9;
  localparam int HUND_W  = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CPR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_NUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_DEN = 2'd2;

  // register reset values
  localparam logic [CPR_W-1:0]  CPR_RST      = 16'd64;
  localparam logic [GEAR_W-1:0] GEAR_NUM_RST = 10'd192;
  localparam logic [GEAR_W-1:0] GEAR_DEN_RST = 10'd10;

  // shared divider sizes
  localparam int DVD_W  = 42;  // widest dividend: |pos| * den
  localparam int DVR_W  = 26;  // widest divisor: cpr * num
  localparam int CNT_W  = 6;
  localparam int WREV_W = 42;  // wheel whole-revolution magnitude

  // arithmetic constants
  localparam int K_MILLI = 1000;
  localparam int K_CDEG  = 36000;
  localparam int K_CENT  = 100;
  localparam int K_DEG       = K_CDEG / K_CENT;   // 360
  localparam int K_FRAC_CDEG = K_CDEG / K_MILLI;  // 36
  // x / 100 as (x * 5243) >> 19, exact for x below 43690
  localparam int K_RECIP_CENT = 5243;
  localparam int K_RECIP_SH   = 19;

  // configuration after the zero guards
  typedef struct packed {
    logic [CPR_W-1:0]  cpr;
    logic [GEAR_W-1:0] num;
    logic [GEAR_W-1:0] den;
  } cfg_t;

  // divider request and status
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // signed whole revolutions from sign and magnitude, clamped to 32 bits
  function automatic logic signed [POS_W-1:0] sat_rev(input logic neg,
                                                      input logic [WREV_W-1:0] mag);
    logic [POS_W-1:0] low;
    low = mag[POS_W-1:0];
    if (!neg) begin
      if (mag > WREV_W'(32'h7FFF_FFFF)) sat_rev = 32'sh7FFF_FFFF;
      else sat_rev = signed'(low);
    end else begin
      if (mag > WREV_W'(32'h8000_0000)) sat_rev = 32'sh8000_0000;
      else sat_rev = signed'(~low + 32'd1);
    end
  endfunction

endpackage : ecra_pkg
`default_nettype wire

>>> rtl/ecra_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecra channel interfaces
// Valid/ready channels for configuration writes, counter samples and results.
// ----------------------------------------------------------------------------
interface ecra_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ecra_pkg::CFG_IDX_W-1:0]   index;
  logic [ecra_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : ecra_cfg_if

interface ecra_in_if;
  logic                         valid;
  logic                         ready;
  logic [ecra_pkg::RAW_W-1:0]   raw_counter;
  modport source (output valid, raw_counter, input ready);
  modport sink   (input valid, raw_counter, output ready);
endinterface : ecra_in_if

interface ecra_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ecra_pkg::POS_W-1:0]   position_count;
  logic signed [ecra_pkg::POS_W-1:0]   motor_rev_whole;
  logic [ecra_pkg::THOU_W-1:0]         motor_rev_thousandths;
  logic signed [ecra_pkg::POS_W-1:0]   wheel_rev_whole;
  logic [ecra_pkg::THOU_W-1:0]         wheel_rev_thousandths;
  logic [ecra_pkg::DEG_W-1:0]          motor_angle_deg;
  logic [ecra_pkg::HUND_W-1:0]         motor_angle_hundredths;
  logic [ecra_pkg::DEG_W-1:0]          wheel_angle_deg;
  logic [ecra_pkg::HUND_W-1:0]         wheel_angle_hundredths;
  modport source (output valid, position_count, motor_rev_whole, motor_rev_thousandths,
                  wheel_rev_whole, wheel_rev_thousandths, motor_angle_deg,
                  motor_angle_hundredths, wheel_angle_deg, wheel_angle_hundredths,
                  input ready);
  modport sink   (input valid, position_count, motor_rev_whole, motor_rev_thousandths,
                  wheel_rev_whole, wheel_rev_thousandths, motor_angle_deg,
                  motor_angle_hundredths, wheel_angle_deg, wheel_angle_hundredths,
                  output ready);
endinterface : ecra_out_if
`default_nettype wire

>>> rtl/ecra_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecra_cfg: configuration registers
// Holds counts per revolution and the gear ratio, applies the zero guards.
// ----------------------------------------------------------------------------
module ecra_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  ecra_cfg_if.sink         cfg,
  output ecra_pkg::cfg_t   cfg_eff
);
  import ecra_pkg::*;

  logic [CPR_W-1:0]  cpr;
  logic [GEAR_W-1:0] num;
  logic [GEAR_W-1:0] den;

  // writes are always taken, unknown indexes are dropped
  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cpr <= CPR_RST;
      num <= GEAR_NUM_RST;
      den <= GEAR_DEN_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CPR:      cpr <= cfg.data;
        REG_GEAR_NUM: num <= cfg.data[GEAR_W-1:0];
        REG_GEAR_DEN: den <= cfg.data[GEAR_W-1:0];
        default:      ;
      endcase
    end
  end

  // zero counts or zero numerator act as one, zero denominator stays
  always_comb begin
    cfg_eff.cpr = (cpr == '0) ? CPR_W'(1) : cpr;
    cfg_eff.num = (num == '0) ? GEAR_W'(1) : num;
    cfg_eff.den = den;
  end

endmodule : ecra_cfg
`default_nettype wire

>>> rtl/ecra_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecra_div: shared restoring divider
// Unsigned divide, one quotient bit per cycle over a left-aligned dividend of
// a requested number of bits.
// ----------------------------------------------------------------------------
module ecra_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ecra_pkg::div_req_t         req,
  input  wire logic [ecra_pkg::DVD_W-1:0] dividend,
  input  wire logic [ecra_pkg::DVR_W-1:0] divisor,
  output ecra_pkg::div_sts_t              sts,
  output logic [ecra_pkg::DVD_W-1:0]      quotient,
  output logic [ecra_pkg::DVR_W-1:0]      remainder
);
  import ecra_pkg::*;

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [DVD_W-1:0]    quo;
  logic [DVR_W-1:0]    rem;
  logic [DVR_W-1:0]    dvr;

  logic [DVR_W:0]      rem_sh;
  logic                ge;
  logic [DVR_W-1:0]    rem_next;

  // one trial subtract per cycle
  always_comb begin
    rem_sh   = {rem, quo[DVD_W-1]};
    ge       = (rem_sh >= {1'b0, dvr});
    rem_next = ge ? DVR_W'(rem_sh - {1'b0, dvr}) : rem_sh[DVR_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvr <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule : ecra_div
`default_nettype wire

>>> rtl/encoder_count_to_rev_angle_top.sv
// Sequence: after a sample transfer, the setup states ST_PREP and ST_MUL, six
//   shared-divider runs and the output load lead to result valid.
// Samples: a new sample is taken only after the last one has finished, also while
//   its result waits in the output register; a stalled result holds the next one.
// Reset (rst, synchronous): position and last counter clear to zero, registers
//   return to 64 counts, gear ratio 192/10, no result pending.
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_count_to_rev_angle_top: encoder position and angle converter
// Extends a 16-bit counter into a 32-bit position and derives motor and wheel
// revolutions and shaft angles through a sequenced shared divider.
// ----------------------------------------------------------------------------
module encoder_count_to_rev_angle_top (
  input  wire logic   clk,
  input  wire logic   rst,
  ecra_cfg_if.sink    cfg,
  ecra_in_if.sink     sample,
  ecra_out_if.source  result
);
  import ecra_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_ISSUE  = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  // division steps, all by a configured divisor
  localparam logic [2:0] OP_MMOD  = 3'd0;  // |pos| / cpr
  localparam logic [2:0] OP_MTHOU = 3'd1;  // motor remainder*1000 / cpr
  localparam logic [2:0] OP_WREV  = 3'd2;  // |pos|*den / (cpr*num)
  localparam logic [2:0] OP_WTHOU = 3'd3;  // wheel remainder*1000 / (cpr*num)
  localparam logic [2:0] OP_MDEG  = 3'd4;  // folded position*360 / cpr
  localparam logic [2:0] OP_MHUND = 3'd5;  // degree remainder*100 / cpr

  // dividend widths of the short steps
  localparam int MTHOU_W = 26;  // (cpr-1) * 1000
  localparam int WTHOU_W = 36;  // (cpr*num-1) * 1000
  localparam int MDEG_W  = 25;  // (cpr-1) * 360
  localparam int MHUND_W = 23;  // (cpr-1) * 100

  cfg_t             cfg_eff;
  div_req_t         div_req;
  div_sts_t         div_sts;
  logic [DVD_W-1:0] div_dvd;
  logic [DVR_W-1:0] div_dvr;
  logic [DVD_W-1:0] div_quo;
  logic [DVR_W-1:0] div_rem;

  logic [2:0]        state;
  logic [2:0]        op;
  logic [RAW_W-1:0]  last_raw;
  logic [POS_W-1:0]  pos;
  logic              neg;
  logic [POS_W-1:0]  mag;
  logic [DVD_W-1:0]  p_wheel;
  logic [DVR_W-1:0]  cpr_num;
  logic [POS_W-1:0]  mwhole;
  logic [CPR_W-1:0]  mrem;
  logic [THOU_W-1:0] mthou;
  logic [WREV_W-1:0] wwhole;
  logic [DVR_W-1:0]  wrem;
  logic [THOU_W-1:0] wthou;
  logic [THOU_W-1:0] wfrac;
  logic [CPR_W-1:0]  mmod;
  logic [DEG_W-1:0]  mdeg;
  logic [CPR_W-1:0]  mdrem;
  logic [HUND_W-1:0] mhund;
  logic [15:0]       wcdeg;
  logic [DEG_W-1:0]  wdeg;
  logic [HUND_W-1:0] whund;
  logic              out_valid;
  logic              out_load;

  logic [RAW_W-1:0]   delta;
  logic [MTHOU_W-1:0] mthou_dvd;
  logic [WTHOU_W-1:0] wthou_dvd;
  logic [MDEG_W-1:0]  mdeg_dvd;
  logic [MHUND_W-1:0] mhund_dvd;

  ecra_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_eff (cfg_eff)
  );

  ecra_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dvd),
    .divisor   (div_dvr),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign sample.ready = (state == ST_IDLE);
  assign delta        = sample.raw_counter - last_raw;
  assign mthou_dvd    = MTHOU_W'(mrem) * MTHOU_W'(K_MILLI);
  assign wthou_dvd    = WTHOU_W'(wrem) * WTHOU_W'(K_MILLI);
  assign mdeg_dvd     = MDEG_W'(mmod) * MDEG_W'(K_DEG);
  assign mhund_dvd    = MHUND_W'(mdrem) * MHUND_W'(K_CENT);
  assign out_load     = (state == ST_FINISH) && (!out_valid || result.ready);

  // operand select, dividends left-aligned to the step's bit count
  always_comb begin
    div_req.start = (state == ST_ISSUE);
    case (op)
      OP_MMOD: begin
        div_req.nbits = CNT_W'(POS_W);
        div_dvd       = {mag, (DVD_W-POS_W)'(0)};
        div_dvr       = DVR_W'(cfg_eff.cpr);
      end
      OP_MTHOU: begin
        div_req.nbits = CNT_W'(MTHOU_W);
        div_dvd       = {mthou_dvd, (DVD_W-MTHOU_W)'(0)};
        div_dvr       = DVR_W'(cfg_eff.cpr);
      end
      OP_WREV: begin
        div_req.nbits = CNT_W'(DVD_W);
        div_dvd       = p_wheel;
        div_dvr       = cpr_num;
      end
      OP_WTHOU: begin
        div_req.nbits = CNT_W'(WTHOU_W);
        div_dvd       = {wthou_dvd, (DVD_W-WTHOU_W)'(0)};
        div_dvr       = cpr_num;
      end
      OP_MDEG: begin
        div_req.nbits = CNT_W'(MDEG_W);
        div_dvd       = {mdeg_dvd, (DVD_W-MDEG_W)'(0)};
        div_dvr       = DVR_W'(cfg_eff.cpr);
      end
      OP_MHUND: begin
        div_req.nbits = CNT_W'(MHUND_W);
        div_dvd       = {mhund_dvd, (DVD_W-MHUND_W)'(0)};
        div_dvr       = DVR_W'(cfg_eff.cpr);
      end
      default: begin
        div_req.nbits = CNT_W'(POS_W);
        div_dvd       = '0;
        div_dvr       = DVR_W'(cfg_eff.cpr);
      end
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_MMOD;
      last_raw  <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            last_raw <= sample.raw_counter;
            pos      <= pos + {{(POS_W-RAW_W){delta[RAW_W-1]}}, delta};
            state    <= ST_PREP;
          end
        end
        ST_PREP:  state <= ST_MUL;
        ST_MUL: begin
          op    <= OP_MMOD;
          state <= ST_ISSUE;
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (div_sts.done) begin
            if (op == OP_MHUND) begin
              state <= ST_FINISH;
            end else begin
              op    <= op + 3'd1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_FINISH: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sign, magnitude and products
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      neg     <= pos[POS_W-1];
      mag     <= pos[POS_W-1] ? (~pos + POS_W'(1)) : pos;
      cpr_num <= DVR_W'(cfg_eff.cpr) * DVR_W'(cfg_eff.num);
    end
    if (state == ST_MUL) begin
      p_wheel <= DVD_W'(mag) * DVD_W'(cfg_eff.den);
    end
    // wheel angle in centidegrees, then whole degrees by reciprocal
    if (state == ST_ISSUE && op == OP_MDEG) begin
      wcdeg <= 16'(wfrac) * 16'(K_FRAC_CDEG);
    end
    if (state == ST_ISSUE && op == OP_MHUND) begin
      wdeg <= DEG_W'((32'(wcdeg) * 32'(K_RECIP_CENT)) >> K_RECIP_SH);
    end
  end

  // capture of each division result
  always_ff @(posedge clk) begin
    if (state == ST_WAIT && div_sts.done) begin
      case (op)
        OP_MMOD: begin
          mwhole <= div_quo[POS_W-1:0];
          mrem   <= div_rem[CPR_W-1:0];
          // position modulo cpr folded into 0..cpr-1
          if (neg && div_rem[CPR_W-1:0] != '0)
            mmod <= cfg_eff.cpr - div_rem[CPR_W-1:0];
          else
            mmod <= div_rem[CPR_W-1:0];
        end
        OP_MTHOU:  mthou <= div_quo[THOU_W-1:0];
        OP_WREV: begin
          wwhole <= div_quo[WREV_W-1:0];
          wrem   <= div_rem;
        end
        OP_WTHOU: begin
          wthou <= div_quo[THOU_W-1:0];
          // fraction folded into 0..999 for the angle
          if (neg && div_quo[THOU_W-1:0] != '0)
            wfrac <= THOU_W'(K_MILLI) - div_quo[THOU_W-1:0];
          else
            wfrac <= div_quo[THOU_W-1:0];
        end
        OP_MDEG: begin
          mdeg  <= div_quo[DEG_W-1:0];
          mdrem <= div_rem[CPR_W-1:0];
        end
        OP_MHUND: begin
          mhund <= div_quo[HUND_W-1:0];
          whund <= HUND_W'(wcdeg - 16'(wdeg) * 16'(K_CENT));
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      result.position_count         <= signed'(pos);
      result.motor_rev_whole        <= sat_rev(neg, WREV_W'(mwhole));
      result.motor_rev_thousandths  <= mthou;
      result.wheel_rev_whole        <= sat_rev(neg, wwhole);
      result.wheel_rev_thousandths  <= wthou;
      result.motor_angle_deg        <= mdeg;
      result.motor_angle_hundredths <= mhund;
      result.wheel_angle_deg        <= wdeg;
      result.wheel_angle_hundredths <= whund;
    end
  end

  assign result.valid = out_valid;

endmodule : encoder_count_to_rev_angle_top
`default_nettype wire

>>> rtl/ecra_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecra_chk: port checker
// Watches the top level's channels for handshake and result range errors.
// ----------------------------------------------------------------------------
module ecra_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [ecra_pkg::POS_W-1:0] position_count,
  input wire logic [ecra_pkg::THOU_W-1:0]   motor_rev_thousandths,
  input wire logic [ecra_pkg::THOU_W-1:0]   wheel_rev_thousandths,
  input wire logic [ecra_pkg::DEG_W-1:0]    motor_angle_deg,
  input wire logic [ecra_pkg::HUND_W-1:0]   motor_angle_hundredths,
  input wire logic [ecra_pkg::DEG_W-1:0]    wheel_angle_deg,
  input wire logic [ecra_pkg::HUND_W-1:0]   wheel_angle_hundredths
);
  import ecra_pkg::*;

  // a result offered stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // a stalled result keeps its position
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(position_count))
    else $error("stalled result changed");

  // the block is busy right after taking a sample
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while still working");

  // derived fields stay in range
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_rev_thousandths < THOU_W'(K_MILLI)) &&
                  (wheel_rev_thousandths < THOU_W'(K_MILLI)) &&
                  (motor_angle_deg < DEG_W'(360)) &&
                  (wheel_angle_deg < DEG_W'(360)) &&
                  (motor_angle_hundredths < HUND_W'(K_CENT)) &&
                  (wheel_angle_hundredths < HUND_W'(K_CENT)))
    else $error("result field out of range");

endmodule : ecra_chk

bind encoder_count_to_rev_angle_top ecra_chk u_chk (
  .clk                    (clk),
  .rst                    (rst),
  .in_valid               (sample.valid),
  .in_ready               (sample.ready),
  .out_valid              (result.valid),
  .out_ready              (result.ready),
  .position_count         (result.position_count),
  .motor_rev_thousandths  (result.motor_rev_thousandths),
  .wheel_rev_thousandths  (result.wheel_rev_thousandths),
  .motor_angle_deg        (result.motor_angle_deg),
  .motor_angle_hundredths (result.motor_angle_hundredths),
  .wheel_angle_deg        (result.wheel_angle_deg),
  .wheel_angle_hundredths (result.wheel_angle_hundredths)
);
`default_nettype wire

>>> tb/encoder_count_to_rev_angle_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_count_to_rev_angle_top_test: self-checking bench for the converter
// Drives counter samples and register writes over valid/ready channels, runs
// an independent 64-bit predictor of position, revolutions and angles, and
// compares every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module encoder_count_to_rev_angle_top_test;
  import ecra_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RST_CYCLES     = 6;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 400;
  localparam int MAX_PRINTS     = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // position beyond which the widest gear setting clamps wheel revolutions
  localparam longint SAT_SPAN = 64'sd2_300_000;

  typedef struct packed {
    logic signed [POS_W-1:0] position_count;
    logic signed [POS_W-1:0] motor_rev_whole;
    logic [THOU_W-1:0]       motor_rev_thousandths;
    logic signed [POS_W-1:0] wheel_rev_whole;
    logic [THOU_W-1:0]       wheel_rev_thousandths;
    logic [DEG_W-1:0]        motor_angle_deg;
    logic [HUND_W-1:0]       motor_angle_hundredths;
    logic [DEG_W-1:0]        wheel_angle_deg;
    logic [HUND_W-1:0]       wheel_angle_hundredths;
  } conv_res_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             has_want;
    conv_res_t        want;
  } sample_row_t;

  // directed samples under reset settings: wrap both ways, half-range steps
  localparam int DIR_N = 16;
  localparam sample_row_t DIR_ROWS [DIR_N] = '{
    '{16'h0000, 1'b1, '{32'sd0, 32'sd0, 10'd0, 32'sd0, 10'd0, 9'd0, 7'd0, 9'd0, 7'd0}},
    '{16'h0040, 1'b1, '{32'sd64, 32'sd1, 10'd0, 32'sd0, 10'd52, 9'd0, 7'd0, 9'd18, 7'd72}},
    '{16'h803F, 1'b0, '0},
    '{16'h003F, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h0001, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'hFFFE, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'h0040, 1'b0, '0},
    '{16'hFFC0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ecra_cfg_if cfg_ch ();
  ecra_in_if  smp_ch ();
  ecra_out_if res_ch ();

  encoder_count_to_rev_angle_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (smp_ch),
    .result (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state and register copy
  logic [RAW_W-1:0]        prev_raw = '0;
  logic signed [POS_W-1:0] pos_acc  = '0;
  logic [CPR_W-1:0]        cpr_reg  = CPR_RST;
  logic [GEAR_W-1:0]       num_reg  = GEAR_NUM_RST;
  logic [GEAR_W-1:0]       den_reg  = GEAR_DEN_RST;

  conv_res_t pending_conv [$];

  int n_fail    = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_writes  = 0;
  int n_sat_hi  = 0;
  int n_sat_lo  = 0;
  int idle_pct  = 0;
  bit hold_req  = 1'b0;

  task automatic report_error(input string msg);
    n_fail++;
    if (n_fail <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             n_results, name, got, want));
  endtask

  function automatic logic signed [POS_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      n_sat_hi++;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      n_sat_lo++;
      return 32'sh8000_0000;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // extend the counter and derive revolutions and angles at 64 bits
  function automatic conv_res_t convert_sample(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] step;
    longint pos, cpr, num, den;
    longint motor_milli, wheel_milli, m_residue, m_centideg, wheel_frac, w_centideg;
    conv_res_t r;
    step = raw - prev_raw;
    pos_acc = pos_acc + {{(POS_W-RAW_W){step[RAW_W-1]}}, step};
    prev_raw = raw;
    pos = pos_acc;
    // zero guards on the divisors; zero denominator passes through
    cpr = (cpr_reg == '0) ? 64'sd1 : longint'(cpr_reg);
    num = (num_reg == '0) ? 64'sd1 : longint'(num_reg);
    den = longint'(den_reg);
    motor_milli = (pos * K_MILLI) / cpr;
    wheel_milli = (pos * K_MILLI * den) / (cpr * num);
    m_residue = pos % cpr;
    if (m_residue < 0) m_residue += cpr;
    m_centideg = (m_residue * K_CDEG) / cpr;
    wheel_frac = wheel_milli % K_MILLI;
    if (wheel_frac < 0) wheel_frac += K_MILLI;
    w_centideg = (wheel_frac * K_CDEG) / K_MILLI;
    r.position_count         = pos_acc;
    r.motor_rev_whole        = clamp32(motor_milli / K_MILLI);
    r.motor_rev_thousandths  = THOU_W'(mag(motor_milli % K_MILLI));
    r.wheel_rev_whole        = clamp32(wheel_milli / K_MILLI);
    r.wheel_rev_thousandths  = THOU_W'(mag(wheel_milli % K_MILLI));
    r.motor_angle_deg        = DEG_W'(m_centideg / K_CENT);
    r.motor_angle_hundredths = HUND_W'(m_centideg % K_CENT);
    r.wheel_angle_deg        = DEG_W'(w_centideg / K_CENT);
    r.wheel_angle_hundredths = HUND_W'(w_centideg % K_CENT);
    return r;
  endfunction

  // register write transfer, mirrored into the register copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_CPR:      cpr_reg = val;
      REG_GEAR_NUM: num_reg = val[GEAR_W-1:0];
      REG_GEAR_DEN: den_reg = val[GEAR_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // sample transfer with an optional idle burst in front
  task automatic send_sample(input logic [RAW_W-1:0] raw, input logic has_want,
                             input conv_res_t want);
    conv_res_t predicted;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      smp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    smp_ch.valid       <= 1'b1;
    smp_ch.raw_counter <= raw;
    do @(posedge clk); while (!smp_ch.ready);
    predicted = convert_sample(raw);
    pending_conv.push_back(has_want ? want : predicted);
    n_samples++;
  endtask

  // next counter value: mostly small moves, some arbitrary, some half-range
  function automatic logic [RAW_W-1:0] pick_raw();
    logic [RAW_W-1:0] step;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      step = RAW_W'($urandom_range(0, 600) - 300);
    end else if (sel < 9) begin
      step = RAW_W'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       step = 16'h7FFF;
        1:       step = 16'h8000;
        default: step = 16'h8001;
      endcase
    end
    return prev_raw + step;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_sample(pick_raw(), 1'b0, '0);
  endtask

  // near-maximal steps up past wheel clamping, then down past it
  task automatic run_ramp();
    while (pos_acc < SAT_SPAN)
      send_sample(prev_raw + RAW_W'($urandom_range(32000, 32767)), 1'b0, '0);
    repeat (6) send_sample(prev_raw + RAW_W'($urandom_range(32000, 32767)), 1'b0, '0);
    while (pos_acc > -SAT_SPAN)
      send_sample(prev_raw - RAW_W'($urandom_range(32000, 32767)), 1'b0, '0);
    repeat (6) send_sample(prev_raw - RAW_W'($urandom_range(32000, 32767)), 1'b0, '0);
  endtask

  // drop valid and wait until every predicted result has arrived
  task automatic settle(input int extra);
    @(negedge clk);
    smp_ch.valid <= 1'b0;
    while (pending_conv.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_random_cfg();
    write_reg(REG_CPR, CFG_DATA_W'($urandom));
    write_reg(REG_GEAR_NUM, CFG_DATA_W'($urandom));
    write_reg(REG_GEAR_DEN, CFG_DATA_W'($urandom));
  endtask

  // result receiver: random stall bursts, long hold on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // result checker against the oldest prediction
  always @(posedge clk) begin
    conv_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (pending_conv.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected, position %0d",
                               n_results, res_ch.position_count));
      end else begin
        want = pending_conv.pop_front();
        check_field("position_count", res_ch.position_count, want.position_count);
        check_field("motor_rev_whole", res_ch.motor_rev_whole, want.motor_rev_whole);
        check_field("motor_rev_thousandths", res_ch.motor_rev_thousandths,
                    want.motor_rev_thousandths);
        check_field("wheel_rev_whole", res_ch.wheel_rev_whole, want.wheel_rev_whole);
        check_field("wheel_rev_thousandths", res_ch.wheel_rev_thousandths,
                    want.wheel_rev_thousandths);
        check_field("motor_angle_deg", res_ch.motor_angle_deg, want.motor_angle_deg);
        check_field("motor_angle_hundredths", res_ch.motor_angle_hundredths,
                    want.motor_angle_hundredths);
        check_field("wheel_angle_deg", res_ch.wheel_angle_deg, want.wheel_angle_deg);
        check_field("wheel_angle_hundredths", res_ch.wheel_angle_hundredths,
                    want.wheel_angle_hundredths);
      end
    end
  end

  // stimulus sequence
  initial begin
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_CPR;
    cfg_ch.data        = '0;
    smp_ch.valid       = 1'b0;
    smp_ch.raw_counter = '0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: directed rows then random moves
    idle_pct = 25;
    for (int i = 0; i < DIR_N; i++)
      send_sample(DIR_ROWS[i].raw, DIR_ROWS[i].has_want, DIR_ROWS[i].want);
    run_random(60);
    settle(8);

    // steepest gear ratio, drive wheel revolutions into clamping both ways
    write_reg(REG_CPR, 16'd1);
    write_reg(REG_GEAR_NUM, 16'd1);
    write_reg(REG_GEAR_DEN, 16'd1023);
    idle_pct = 10;
    run_ramp();
    settle(8);

    // zero counts and zero gears via masked upper bits, plus an ignored index
    write_reg(REG_CPR, 16'd0);
    write_reg(REG_GEAR_NUM, 16'hFC00);
    write_reg(REG_GEAR_DEN, 16'hFC00);
    write_reg(REG_UNUSED, 16'hFFFF);
    idle_pct = 25;
    run_random(50);
    settle(8);
    write_reg(REG_GEAR_DEN, 16'hFFFF);
    run_random(40);
    settle(8);

    // largest divisor
    write_reg(REG_CPR, 16'hFFFF);
    write_reg(REG_GEAR_NUM, 16'd1023);
    write_reg(REG_GEAR_DEN, 16'd1);
    run_random(60);
    settle(8);

    // random settings, each with a long result hold that backs up the input
    repeat (2) begin
      write_random_cfg();
      run_random(40);
      hold_req = 1'b1;
      run_random(40);
      settle(8);
    end

    // closing stretch without idling
    idle_pct = 0;
    write_random_cfg();
    run_random(100);
    settle(DRAIN_CYCLES);

    $display("covered %0d sample transfers, %0d results checked, %0d register writes",
             n_samples, n_results, n_writes);
    $display("whole revolutions clamped high %0d times and low %0d times",
             n_sat_hi, n_sat_lo);
    if (n_fail == 0) begin
      $display("PASS encoder_count_to_rev_angle_top");
    end else begin
      $display("FAIL encoder_count_to_rev_angle_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL encoder_count_to_rev_angle_top");
    $finish;
  end

endmodule : encoder_count_to_rev_angle_top_test
`default_nettype wire
